// ===== rtl/rcoc_pkg.sv =====
// Shared constants and a helper function for the rectangular copy overlap checker.
package rcoc_pkg;

   // Fixed row-pitch field width and the width of the wrapping address arithmetic
   localparam int ROW_PITCH_BITS = 24;
   localparam int WORD_BITS      = 64;

   typedef logic [WORD_BITS-1:0] word_type;

   // True when a block of length len at offset b sits in the gap after the
   // block at offset a, inside one period.
   function automatic logic fits_gap(word_type a, word_type b, word_type len, word_type period);
      word_type a_end;
      word_type b_end;
      word_type a_lim;
      a_end = a + len;
      b_end = b + len;
      a_lim = a + period;
      return (b >= a_end) && (b_end <= a_lim);
   endfunction

endpackage

// ===== rtl/rcoc_rem_pipe.sv =====
// Pipelined restoring remainder unit: several lanes, one dividend bit per stage.
module rcoc_rem_pipe #(
   parameter int LANES     = 4,
   parameter int NUM_BITS  = 41,
   parameter int DEN_BITS  = 40,
   parameter int SIDE_BITS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic [LANES-1:0][NUM_BITS-1:0]       in_num,
   input  logic [LANES-1:0][DEN_BITS-1:0]       in_den,
   input  logic [SIDE_BITS-1:0]                 in_side,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic [LANES-1:0][DEN_BITS-1:0]       out_rem,
   output logic [SIDE_BITS-1:0]                 out_side
);

   // Stage registers
   logic [NUM_BITS-1:0]                   vld_ff;
   logic [LANES-1:0][NUM_BITS-1:0]        num_ff  [NUM_BITS];
   logic [LANES-1:0][DEN_BITS-1:0]        den_ff  [NUM_BITS];
   logic [LANES-1:0][DEN_BITS-1:0]        rem_ff  [NUM_BITS];
   logic [SIDE_BITS-1:0]                  side_ff [NUM_BITS];
   logic [NUM_BITS:0]                     rdy;

   // Ready chain: a stage loads when empty or when its successor loads
   assign rdy[NUM_BITS] = out_ready;
   assign in_ready      = rdy[0];

   for (genvar k = 0; k < NUM_BITS; k++) begin : g_stage
      logic                           prev_vld;
      logic [LANES-1:0][NUM_BITS-1:0] prev_num;
      logic [LANES-1:0][DEN_BITS-1:0] prev_den;
      logic [LANES-1:0][DEN_BITS-1:0] prev_rem;
      logic [SIDE_BITS-1:0]           prev_side;
      logic [LANES-1:0][DEN_BITS-1:0] rem_in;

      assign rdy[k] = !vld_ff[k] || rdy[k+1];

      if (k == 0) begin : g_first
         assign prev_vld  = in_valid;
         assign prev_num  = in_num;
         assign prev_den  = in_den;
         assign prev_rem  = '0;
         assign prev_side = in_side;
      end else begin : g_next
         assign prev_vld  = vld_ff[k-1];
         assign prev_num  = num_ff[k-1];
         assign prev_den  = den_ff[k-1];
         assign prev_rem  = rem_ff[k-1];
         assign prev_side = side_ff[k-1];
      end

      // One shift, compare and subtract per lane
      always_comb begin
         logic [DEN_BITS:0] trial;
         logic [DEN_BITS:0] dext;
         for (int l = 0; l < LANES; l++) begin
            trial = {prev_rem[l], prev_num[l][NUM_BITS-1-k]};
            dext  = {1'b0, prev_den[l]};
            if (trial >= dext) begin
               trial = trial - dext;
            end
            rem_in[l] = trial[DEN_BITS-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            vld_ff[k] <= prev_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[k]) begin
            num_ff[k]  <= prev_num;
            den_ff[k]  <= prev_den;
            rem_ff[k]  <= rem_in;
            side_ff[k] <= prev_side;
         end
      end
   end

   assign out_valid = vld_ff[NUM_BITS-1];
   assign out_rem   = rem_ff[NUM_BITS-1];
   assign out_side  = side_ff[NUM_BITS-1];

endmodule

// ===== rtl/rect_copy_overlap_check.sv =====
// Top level of the rectangular 3-D copy overlap checker.
//
// Takes one copy descriptor per item and returns one item with the overlap
// flag. A new item is taken every cycle while the pipeline is not stalled.
// An item passes through the front stages of pitch defaulting, products and
// span tests, the pipelined remainder unit that reduces origins modulo the
// row and slice pitches, with a stage per bit of the row-offset dividend
// (COORD_BITS + 25), and one output register. Backpressure stalls only the
// stages that are full, so bubbles are squeezed out while a result waits.
module rect_copy_overlap_check #(
   parameter int COORD_BITS = 16,
   parameter int PITCH_BITS = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // src_x, src_y, src_z, dst_x, dst_y, dst_z, width, height, depth,
   // row_stride, slice_stride (lowest bits first), zero padded to bytes
   input  logic [((9*COORD_BITS+rcoc_pkg::ROW_PITCH_BITS+PITCH_BITS+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // overlap in bit 0, rest zero
   output logic [7:0] rsp_tdata
);
   import rcoc_pkg::*;

   localparam int CB   = COORD_BITS;
   localparam int RPB  = ROW_PITCH_BITS;
   localparam int PB   = CB + RPB;
   localparam int LIN  = PB + 1;
   localparam int SPW  = (PITCH_BITS > PB) ? PITCH_BITS : PB;
   localparam int SIDE = CB + RPB + SPW + LIN + 1;

   typedef struct packed {
      logic [CB-1:0]         sx, sy, sz, dx, dy, dz, w, h, d;
      logic [RPB-1:0]        rp;
      logic [PITCH_BITS-1:0] sp_in;
   } s1_type;

   typedef struct packed {
      logic [CB-1:0]         sx, dx, sz, dz, w, d;
      logic [RPB-1:0]        rp;
      logic [PITCH_BITS-1:0] sp_in;
      logic [PB-1:0]         hrp, hm1rp, syrp, dyrp;
   } s2_type;

   typedef struct packed {
      logic [CB-1:0]  sx, dx, sz, dz, w, d;
      logic [RPB-1:0] rp;
      logic [SPW-1:0] sp;
      logic [LIN-1:0] slice_len, s_lin, d_lin;
   } s3_type;

   typedef struct packed {
      logic [CB-1:0]  sx, dx, w;
      logic [RPB-1:0] rp;
      logic [SPW-1:0] sp;
      logic [LIN-1:0] slice_len, s_lin, d_lin;
      word_type       szsp, dzsp, dm1sp;
   } s4_type;

   typedef struct packed {
      logic [CB-1:0]  sx, dx, w;
      logic [RPB-1:0] rp;
      logic [SPW-1:0] sp;
      logic [LIN-1:0] slice_len, s_lin, d_lin;
      word_type       s_start, d_start, block_len;
   } s5_type;

   typedef struct packed {
      logic [CB-1:0]  sx, dx, w;
      logic [RPB-1:0] rp;
      logic [SPW-1:0] sp;
      logic [LIN-1:0] slice_len, s_lin, d_lin;
      logic           disjoint;
   } s6_type;

   logic   v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   s4_type s4_ff, s4_in;
   s5_type s5_ff, s5_in;
   s6_type s6_ff, s6_in;
   logic   rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, div_in_ready;

   logic                        div_valid, div_ready;
   logic [3:0][LIN-1:0]         div_num;
   logic [3:0][SPW-1:0]         div_den;
   logic [3:0][SPW-1:0]         div_rem;
   logic [SIDE-1:0]             div_side_in, div_side_out;

   logic rsp_tvalid_ff, overlap_ff, overlap_in;

   // Ready chain over the front stages
   assign rdy6       = !v6_ff || div_in_ready;
   assign rdy5       = !v5_ff || rdy6;
   assign rdy4       = !v4_ff || rdy5;
   assign rdy3       = !v3_ff || rdy4;
   assign rdy2       = !v2_ff || rdy3;
   assign rdy1       = !v1_ff || rdy2;
   assign req_tready = rdy1;

   // Stage 1: unpack, zero extents become one, default the row pitch
   always_comb begin
      logic [RPB-1:0] rp_raw;
      s1_in.sx    = req_tdata[0*CB +: CB];
      s1_in.sy    = req_tdata[1*CB +: CB];
      s1_in.sz    = req_tdata[2*CB +: CB];
      s1_in.dx    = req_tdata[3*CB +: CB];
      s1_in.dy    = req_tdata[4*CB +: CB];
      s1_in.dz    = req_tdata[5*CB +: CB];
      s1_in.w     = req_tdata[6*CB +: CB];
      s1_in.h     = req_tdata[7*CB +: CB];
      s1_in.d     = req_tdata[8*CB +: CB];
      rp_raw      = req_tdata[9*CB +: RPB];
      s1_in.sp_in = req_tdata[9*CB+RPB +: PITCH_BITS];
      if (s1_in.w == '0) begin
         s1_in.w = CB'(1);
      end
      if (s1_in.h == '0) begin
         s1_in.h = CB'(1);
      end
      if (s1_in.d == '0) begin
         s1_in.d = CB'(1);
      end
      s1_in.rp = (rp_raw == '0) ? RPB'(s1_in.w) : rp_raw;
   end

   // Stage 2: row products
   always_comb begin
      s2_in.sx    = s1_ff.sx;
      s2_in.dx    = s1_ff.dx;
      s2_in.sz    = s1_ff.sz;
      s2_in.dz    = s1_ff.dz;
      s2_in.w     = s1_ff.w;
      s2_in.d     = s1_ff.d;
      s2_in.rp    = s1_ff.rp;
      s2_in.sp_in = s1_ff.sp_in;
      s2_in.hrp   = PB'(s1_ff.h) * PB'(s1_ff.rp);
      s2_in.hm1rp = PB'(s1_ff.h - CB'(1)) * PB'(s1_ff.rp);
      s2_in.syrp  = PB'(s1_ff.sy) * PB'(s1_ff.rp);
      s2_in.dyrp  = PB'(s1_ff.dy) * PB'(s1_ff.rp);
   end

   // Stage 3: slice pitch default, slice length, in-slice linear offsets
   always_comb begin
      s3_in.sx        = s2_ff.sx;
      s3_in.dx        = s2_ff.dx;
      s3_in.sz        = s2_ff.sz;
      s3_in.dz        = s2_ff.dz;
      s3_in.w         = s2_ff.w;
      s3_in.d         = s2_ff.d;
      s3_in.rp        = s2_ff.rp;
      s3_in.sp        = (s2_ff.sp_in != '0) ? SPW'(s2_ff.sp_in) : SPW'(s2_ff.hrp);
      s3_in.slice_len = LIN'(s2_ff.hm1rp) + LIN'(s2_ff.w);
      s3_in.s_lin     = LIN'(s2_ff.syrp) + LIN'(s2_ff.sx);
      s3_in.d_lin     = LIN'(s2_ff.dyrp) + LIN'(s2_ff.dx);
   end

   // Stage 4: slice products, wrapped to the word width
   always_comb begin
      s4_in.sx        = s3_ff.sx;
      s4_in.dx        = s3_ff.dx;
      s4_in.w         = s3_ff.w;
      s4_in.rp        = s3_ff.rp;
      s4_in.sp        = s3_ff.sp;
      s4_in.slice_len = s3_ff.slice_len;
      s4_in.s_lin     = s3_ff.s_lin;
      s4_in.d_lin     = s3_ff.d_lin;
      s4_in.szsp      = WORD_BITS'(s3_ff.sz) * WORD_BITS'(s3_ff.sp);
      s4_in.dzsp      = WORD_BITS'(s3_ff.dz) * WORD_BITS'(s3_ff.sp);
      s4_in.dm1sp     = WORD_BITS'(s3_ff.d - CB'(1)) * WORD_BITS'(s3_ff.sp);
   end

   // Stage 5: start addresses and block length
   always_comb begin
      s5_in.sx        = s4_ff.sx;
      s5_in.dx        = s4_ff.dx;
      s5_in.w         = s4_ff.w;
      s5_in.rp        = s4_ff.rp;
      s5_in.sp        = s4_ff.sp;
      s5_in.slice_len = s4_ff.slice_len;
      s5_in.s_lin     = s4_ff.s_lin;
      s5_in.d_lin     = s4_ff.d_lin;
      s5_in.s_start   = s4_ff.szsp + WORD_BITS'(s4_ff.s_lin);
      s5_in.d_start   = s4_ff.dzsp + WORD_BITS'(s4_ff.d_lin);
      s5_in.block_len = s4_ff.dm1sp + WORD_BITS'(s4_ff.slice_len);
   end

   // Stage 6: linear span test
   always_comb begin
      word_type d_end;
      word_type s_end;
      s6_in.sx        = s5_ff.sx;
      s6_in.dx        = s5_ff.dx;
      s6_in.w         = s5_ff.w;
      s6_in.rp        = s5_ff.rp;
      s6_in.sp        = s5_ff.sp;
      s6_in.slice_len = s5_ff.slice_len;
      s6_in.s_lin     = s5_ff.s_lin;
      s6_in.d_lin     = s5_ff.d_lin;
      d_end           = s5_ff.d_start + s5_ff.block_len;
      s_end           = s5_ff.s_start + s5_ff.block_len;
      s6_in.disjoint  = (d_end <= s5_ff.s_start) || (s_end <= s5_ff.d_start);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_tvalid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
         if (rdy6) v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) s1_ff <= s1_in;
      if (rdy2) s2_ff <= s2_in;
      if (rdy3) s3_ff <= s3_in;
      if (rdy4) s4_ff <= s4_in;
      if (rdy5) s5_ff <= s5_in;
      if (rdy6) s6_ff <= s6_in;
   end

   // Remainders: column offsets by row pitch, in-slice offsets by slice pitch
   assign div_num[0]  = LIN'(s6_ff.sx);
   assign div_num[1]  = LIN'(s6_ff.dx);
   assign div_num[2]  = s6_ff.s_lin;
   assign div_num[3]  = s6_ff.d_lin;
   assign div_den[0]  = SPW'(s6_ff.rp);
   assign div_den[1]  = SPW'(s6_ff.rp);
   assign div_den[2]  = s6_ff.sp;
   assign div_den[3]  = s6_ff.sp;
   assign div_side_in = {s6_ff.w, s6_ff.rp, s6_ff.sp, s6_ff.slice_len, s6_ff.disjoint};

   rcoc_rem_pipe #(
      .LANES     (4),
      .NUM_BITS  (LIN),
      .DEN_BITS  (SPW),
      .SIDE_BITS (SIDE)
   ) u_rem (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v6_ff),
      .in_ready  (div_in_ready),
      .in_num    (div_num),
      .in_den    (div_den),
      .in_side   (div_side_in),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_rem   (div_rem),
      .out_side  (div_side_out)
   );

   // Row-gap and slice-gap tests, then the output register
   always_comb begin
      logic [CB-1:0]  w;
      logic [RPB-1:0] rp;
      logic [SPW-1:0] sp;
      logic [LIN-1:0] slice_len;
      logic           disjoint;
      logic           row_fit;
      logic           slice_fit;
      {w, rp, sp, slice_len, disjoint} = div_side_out;
      row_fit   = fits_gap(WORD_BITS'(div_rem[0]), WORD_BITS'(div_rem[1]),
                           WORD_BITS'(w), WORD_BITS'(rp))
               || fits_gap(WORD_BITS'(div_rem[1]), WORD_BITS'(div_rem[0]),
                           WORD_BITS'(w), WORD_BITS'(rp));
      slice_fit = fits_gap(WORD_BITS'(div_rem[2]), WORD_BITS'(div_rem[3]),
                           WORD_BITS'(slice_len), WORD_BITS'(sp))
               || fits_gap(WORD_BITS'(div_rem[3]), WORD_BITS'(div_rem[2]),
                           WORD_BITS'(slice_len), WORD_BITS'(sp));
      overlap_in = !(disjoint || row_fit || slice_fit);
   end

   assign div_ready = !rsp_tvalid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (div_ready) begin
         rsp_tvalid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (div_ready) begin
         overlap_ff <= overlap_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {7'b0, overlap_ff};

endmodule

// ===== rtl/rcoc_checker.sv =====
// Port-level checker for the overlap checker, bound to the top level.
module rcoc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   logic [7:0] pending_ff, pending_in;
   logic       req_acc, rsp_acc;

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;

   // Items taken in but not yet delivered
   always_comb begin
      pending_in = pending_ff;
      if (req_acc && !rsp_acc) begin
         pending_in = pending_ff + 8'd1;
      end else if (!req_acc && rsp_acc) begin
         pending_in = pending_ff - 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 8'd0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped or changed while stalled");

   // No result without an item behind it
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pending_ff != 8'd0)
      else $error("result with no pending item");

   // Nothing comes out straight after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

   // Padding bits stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:1] == 7'd0)
      else $error("result padding not zero");

endmodule

bind rect_copy_overlap_check rcoc_checker u_rcoc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
